@@ rtl/core/ccfd_pkg.sv @@
// shared types, constants and crc step function for the cobs crc frame decoder
`timescale 1ns / 1ps
package ccfd_pkg;

   localparam int MAX_FRAME = 1024;
   localparam int CNT_W     = 11;

   localparam logic [15:0] CRC_INIT_WIDE   = 16'hFFFF;
   localparam logic [15:0] CRC_INIT_NARROW = 16'h0001;
   localparam logic [7:0]  CODE_FULL       = 8'hFF;
   localparam logic [CNT_W-1:0] MIN_LEN_WIDE   = CNT_W'(4);
   localparam logic [CNT_W-1:0] MIN_LEN_NARROW = CNT_W'(3);
   localparam logic [CNT_W-1:0] CNT_MAX        = CNT_W'(MAX_FRAME);

   // frame status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_CRC    = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_CRC_MODE    = 2'd0;
   localparam logic [1:0] CSR_POLY_WIDE   = 2'd1;
   localparam logic [1:0] CSR_POLY_NARROW = 2'd2;

   typedef struct packed {
      logic [7:0] enc_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             byte_valid;
      logic             frame_end;
      logic [1:0]       status;
      logic [CNT_W-1:0] decoded_len;
   } rsp_type;

   typedef struct packed {
      logic        crc_mode;
      logic [15:0] poly_wide;
      logic [7:0]  poly_narrow;
   } cfg_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic             first;
      logic             emit;
      logic [7:0]       emit_val;
      logic             last;
      logic             decode_err;
      logic [CNT_W-1:0] len;
   } op_type;

   // one byte through the msb-first crc, wide or narrow per mode
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b,
                                              input cfg_type cfg);
      logic [15:0] c;
      logic [7:0]  n;
      c = crc ^ {b, 8'h00};
      n = crc[7:0] ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ cfg.poly_wide) : {c[14:0], 1'b0};
         n = n[7] ? ({n[6:0], 1'b0} ^ cfg.poly_narrow) : {n[6:0], 1'b0};
      end
      return cfg.crc_mode ? {8'h00, n} : c;
   endfunction

endpackage

@@ rtl/core/cobs_crc_frame_decoder.sv @@
// top level of the cobs frame decoder with crc check
`timescale 1ns / 1ps
// Usage:
//   Input side is a queue: drive req_item (one encoded byte, frame_last on the
//   frame's final byte) and raise push; the transfer happens when full is low.
//   Result side is a queue: while empty is low, rsp_item holds the oldest
//   result; raise pop to take it. A byte yields a result when it decodes to a
//   data byte or ends the frame; other bytes yield none.
//   Throughput is one byte per cycle while full is low. A byte's classified
//   form is registered in the queue between front and back, and its result in
//   the result queue; the crc back end runs a byte's eight crc bit steps combinationally.
//   When pop stays low the two-entry result queue fills, the back end halts,
//   the two-entry queue between front and back fills and full rises; nothing
//   is dropped.
//   Configuration writes (index, data) transfer when valid is high; ready is
//   always high. Write only while no frame byte is in flight.
//   Synchronous reset empties both queues, clears the frame state and sets
//   crc_mode 0, poly_wide 0x1021, poly_narrow 0x07.
module cobs_crc_frame_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ccfd_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output ccfd_pkg::rsp_type rsp_item,
   input  logic              valid,
   output logic              ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import ccfd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  front_op;
   op_type  head_op;
   logic    accept;
   logic    op_avail;
   logic    op_pop;

   assign ready  = 1'b1;
   assign accept = push && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_CRC_MODE:    cfg_in.crc_mode    = csr_data[0];
            CSR_POLY_WIDE:   cfg_in.poly_wide   = csr_data;
            CSR_POLY_NARROW: cfg_in.poly_narrow = csr_data[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_mode    <= 1'b0;
         cfg_ff.poly_wide   <= 16'h1021;
         cfg_ff.poly_narrow <= 8'h07;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .op       (front_op)
   );

   ccfd_op_queue u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .push_op (front_op),
      .full    (full),
      .pop     (op_pop),
      .avail   (op_avail),
      .head_op (head_op)
   );

   ccfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_avail (op_avail),
      .op       (head_op),
      .op_pop   (op_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   a_reset_clears : assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_no_blank_rsp : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.byte_valid || rsp_item.frame_end))
      else $error("result without data byte or frame end");

   a_mid_frame_quiet : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.frame_end) |->
         (rsp_item.status == ST_OK && rsp_item.decoded_len == '0))
      else $error("status or length set on a mid-frame result");

   a_blank_byte_zero : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.byte_valid) |-> (rsp_item.data_byte == 8'h00))
      else $error("data byte nonzero without byte_valid");

endmodule

@@ rtl/core/ccfd_front.sv @@
// front end: cobs group tracking, frame counters and byte classification
`timescale 1ns / 1ps
module ccfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  ccfd_pkg::req_type req_item,
   input  ccfd_pkg::cfg_type cfg,
   output ccfd_pkg::op_type  op
);
   import ccfd_pkg::*;

   logic [7:0]       group_left_ff, group_left_in;
   logic             last_code_full_ff, last_code_full_in;
   logic             seen_code_ff, seen_code_in;
   logic [CNT_W-1:0] in_count_ff, in_count_in;
   logic [CNT_W-1:0] out_count_ff, out_count_in;
   logic             decode_fault_ff, decode_fault_in;

   logic             emit_raw;
   logic             emit;
   logic [7:0]       emit_val;
   logic [CNT_W-1:0] in_cnt_nx;
   logic [CNT_W-1:0] out_cnt_nx;
   logic [7:0]       gl_nx;
   logic             lcf_nx;
   logic             seen_nx;
   logic             fault_nx;
   logic [CNT_W-1:0] min_len;

   always_comb begin
      emit_raw = 1'b0;
      emit_val = 8'h00;
      gl_nx    = group_left_ff;
      lcf_nx   = last_code_full_ff;
      seen_nx  = seen_code_ff;
      fault_nx = decode_fault_ff;
      if (group_left_ff == 8'h00) begin
         if (req_item.enc_byte == 8'h00) begin
            fault_nx = 1'b1;
         end else begin
            // boundary zero of the previous group comes out with the next code
            emit_raw = seen_code_ff && !last_code_full_ff;
            gl_nx    = req_item.enc_byte - 8'd1;
            lcf_nx   = (req_item.enc_byte == CODE_FULL);
            seen_nx  = 1'b1;
         end
      end else begin
         emit_raw = 1'b1;
         emit_val = req_item.enc_byte;
         gl_nx    = group_left_ff - 8'd1;
      end
      emit       = emit_raw && !fault_nx;
      in_cnt_nx  = (in_count_ff != CNT_MAX) ? in_count_ff + CNT_W'(1) : in_count_ff;
      out_cnt_nx = (emit && out_count_ff != CNT_MAX) ? out_count_ff + CNT_W'(1)
                                                     : out_count_ff;
      min_len    = cfg.crc_mode ? MIN_LEN_NARROW : MIN_LEN_WIDE;

      op.first      = (in_count_ff == '0);
      op.emit       = emit;
      op.emit_val   = emit ? emit_val : 8'h00;
      op.last       = req_item.frame_last;
      op.decode_err = fault_nx || (gl_nx != 8'h00) || (in_cnt_nx < min_len);
      op.len        = out_cnt_nx;

      if (req_item.frame_last) begin
         group_left_in     = 8'h00;
         last_code_full_in = 1'b0;
         seen_code_in      = 1'b0;
         in_count_in       = '0;
         out_count_in      = '0;
         decode_fault_in   = 1'b0;
      end else begin
         group_left_in     = gl_nx;
         last_code_full_in = lcf_nx;
         seen_code_in      = seen_nx;
         in_count_in       = in_cnt_nx;
         out_count_in      = out_cnt_nx;
         decode_fault_in   = fault_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_left_ff     <= 8'h00;
         last_code_full_ff <= 1'b0;
         seen_code_ff      <= 1'b0;
         in_count_ff       <= '0;
         out_count_ff      <= '0;
         decode_fault_ff   <= 1'b0;
      end else if (accept) begin
         group_left_ff     <= group_left_in;
         last_code_full_ff <= last_code_full_in;
         seen_code_ff      <= seen_code_in;
         in_count_ff       <= in_count_in;
         out_count_ff      <= out_count_in;
         decode_fault_ff   <= decode_fault_in;
      end
   end

endmodule

@@ rtl/core/ccfd_op_queue.sv @@
// two-entry queue of classified bytes between front and back
`timescale 1ns / 1ps
module ccfd_op_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ccfd_pkg::op_type  push_op,
   output logic             full,
   input  logic             pop,
   output logic             avail,
   output ccfd_pkg::op_type  head_op
);
   import ccfd_pkg::*;

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign avail   = (count_ff != 2'd0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/ccfd_back.sv @@
// back end: running crc, frame verdict and result queue
`timescale 1ns / 1ps
module ccfd_back (
   input  logic             clock,
   input  logic             reset,
   input  ccfd_pkg::cfg_type cfg,
   input  logic             op_avail,
   input  ccfd_pkg::op_type  op,
   output logic             op_pop,
   output logic             empty,
   input  logic             pop,
   output ccfd_pkg::rsp_type rsp_item
);
   import ccfd_pkg::*;

   logic [15:0] crc_ff, crc_in;
   rsp_type     rsp_entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;

   logic [15:0] crc_base;
   logic [15:0] residue;
   logic        has_rsp;
   logic        rsp_push;
   logic        rsp_pop;
   rsp_type     rsp_new;

   always_comb begin
      crc_base = op.first ? (cfg.crc_mode ? CRC_INIT_NARROW : CRC_INIT_WIDE) : crc_ff;
      crc_in   = op.emit ? crc_update(crc_base, op.emit_val, cfg) : crc_base;
      residue  = cfg.crc_mode ? {8'h00, crc_in[7:0]} : crc_in;
      has_rsp  = op.emit || op.last;

      rsp_new.data_byte   = op.emit_val;
      rsp_new.byte_valid  = op.emit;
      rsp_new.frame_end   = op.last;
      rsp_new.status      = ST_OK;
      rsp_new.decoded_len = '0;
      if (op.last) begin
         rsp_new.decoded_len = op.len;
         if (op.decode_err) begin
            rsp_new.status = ST_DECODE;
         end else if (residue != 16'h0000) begin
            rsp_new.status = ST_CRC;
         end
      end

      // silent bytes drain freely, the rest need a free result slot
      op_pop   = op_avail && (!has_rsp || count_ff != 2'd2);
      rsp_push = op_pop && has_rsp;
      rsp_pop  = pop && !empty;
      count_in = count_ff + {1'b0, rsp_push} - {1'b0, rsp_pop};
   end

   assign empty    = (count_ff == 2'd0);
   assign rsp_item = rsp_entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_entry_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT_WIDE;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (op_pop) begin
            crc_ff <= crc_in;
         end
         if (rsp_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule
